// File: rtl/mat2_pkg.sv
// Shared types, widths and opcode definitions for the 2x2 matrix ALU.
`timescale 1ns / 1ps

package mat2_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FUNC_W     = 4;
    localparam int N_ELEM     = 4;

    // full product, product after the Q shift, sum of two shifted products
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SHR_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SHR_W + 1;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef enum logic [FUNC_W-1:0] {
        FN_MUL22   = 4'd0,
        FN_MUL21   = 4'd1,
        FN_DOT     = 4'd2,
        FN_OUTER   = 4'd3,
        FN_ROWMUL  = 4'd4,
        FN_ADD22   = 4'd5,
        FN_SUB22   = 4'd6,
        FN_SUB21   = 4'd7,
        FN_ADD21   = 4'd8,
        FN_TRANS   = 4'd9,
        FN_SCALE21 = 4'd10,
        FN_SCALE22 = 4'd11
    } t_func;

    typedef enum logic [2:0] {
        LM_PASS = 3'd0,
        LM_MUL1 = 3'd1,
        LM_MUL2 = 3'd2,
        LM_ADD  = 3'd3,
        LM_SUB  = 3'd4
    } t_lane_mode;

    // operands and operation for one result element
    typedef struct packed {
        t_lane_mode mode;
        t_word      x1;
        t_word      y1;
        t_word      x2;
        t_word      y2;
    } t_lane_cmd;

    function automatic t_lane_cmd mk_cmd(t_lane_mode m, t_word x1, t_word y1,
                                         t_word x2, t_word y2);
        t_lane_cmd c;
        c.mode = m;
        c.x1   = x1;
        c.y1   = y1;
        c.x2   = x2;
        c.y2   = y2;
        return c;
    endfunction

endpackage

// File: rtl/mat2_lane.sv
// One result element: one or two Q-format products (summed), an add/sub or a pass-through, then saturation.
`timescale 1ns / 1ps

module mat2_lane
    import mat2_pkg::*;
(
    input  t_lane_cmd i_cmd,
    output t_word     o_val,
    output logic      o_sat
);

    logic signed [PROD_W-1:0] p1, p2;
    logic signed [PROD_W-1:0] p1_sh, p2_sh;
    logic signed [SUM_W-1:0]  t1, t2, x1_e, y1_e;
    logic signed [SUM_W-1:0]  acc;
    logic [SUM_W-DATA_WIDTH:0] top_bits;

    assign p1    = PROD_W'(i_cmd.x1) * PROD_W'(i_cmd.y1);
    assign p2    = PROD_W'(i_cmd.x2) * PROD_W'(i_cmd.y2);
    // arithmetic shift = floor rounding
    assign p1_sh = p1 >>> FRAC_BITS;
    assign p2_sh = p2 >>> FRAC_BITS;
    assign t1    = {p1_sh[SHR_W-1], p1_sh[SHR_W-1:0]};
    assign t2    = {p2_sh[SHR_W-1], p2_sh[SHR_W-1:0]};
    assign x1_e  = {{(SUM_W-DATA_WIDTH){i_cmd.x1[DATA_WIDTH-1]}}, i_cmd.x1};
    assign y1_e  = {{(SUM_W-DATA_WIDTH){i_cmd.y1[DATA_WIDTH-1]}}, i_cmd.y1};

    always_comb begin
        unique case (i_cmd.mode)
            LM_MUL1: acc = t1;
            LM_MUL2: acc = t1 + t2;
            LM_ADD:  acc = x1_e + y1_e;
            LM_SUB:  acc = x1_e - y1_e;
            default: acc = x1_e;
        endcase
    end

    // in range only when all bits above the sign bit match it
    assign top_bits = acc[SUM_W-1:DATA_WIDTH-1];
    assign o_sat    = !((&top_bits) || !(|top_bits));

    always_comb begin
        if (!o_sat) begin
            o_val = acc[DATA_WIDTH-1:0];
        end else if (acc[SUM_W-1]) begin
            o_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            o_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

endmodule

// File: rtl/mat2_core.sv
// Opcode decode onto four element lanes, write mask and saturation flag.
`timescale 1ns / 1ps

module mat2_core
    import mat2_pkg::*;
(
    input  logic [FUNC_W-1:0] i_func,
    input  t_word             i_a [N_ELEM],
    input  t_word             i_b [N_ELEM],
    input  t_word             i_scalar,
    output t_word             o_val [N_ELEM],
    output logic [N_ELEM-1:0] o_wmask,
    output logic              o_sat
);

    t_lane_cmd         cmd [N_ELEM];
    logic [N_ELEM-1:0] lane_sat;
    t_word             a11, a12, a21, a22, b11, b12, b21, b22, s;

    assign a11 = i_a[0];
    assign a12 = i_a[1];
    assign a21 = i_a[2];
    assign a22 = i_a[3];
    assign b11 = i_b[0];
    assign b12 = i_b[1];
    assign b21 = i_b[2];
    assign b22 = i_b[3];
    assign s   = i_scalar;

    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            cmd[i] = mk_cmd(LM_PASS, '0, '0, '0, '0);
        end
        o_wmask = '0;
        unique case (t_func'(i_func))
            FN_MUL22: begin
                cmd[0]  = mk_cmd(LM_MUL2, a11, b11, a12, b21);
                cmd[1]  = mk_cmd(LM_MUL2, a11, b12, a12, b22);
                cmd[2]  = mk_cmd(LM_MUL2, a21, b11, a22, b21);
                cmd[3]  = mk_cmd(LM_MUL2, a21, b12, a22, b22);
                o_wmask = 4'b1111;
            end
            FN_MUL21: begin
                cmd[0]  = mk_cmd(LM_MUL2, a11, b11, a12, b12);
                cmd[1]  = mk_cmd(LM_MUL2, a21, b11, a22, b12);
                o_wmask = 4'b0011;
            end
            FN_DOT: begin
                cmd[0]  = mk_cmd(LM_MUL2, a11, b11, a12, b12);
                o_wmask = 4'b0001;
            end
            FN_OUTER: begin
                cmd[0]  = mk_cmd(LM_MUL1, a11, b11, '0, '0);
                cmd[1]  = mk_cmd(LM_MUL1, a11, b12, '0, '0);
                cmd[2]  = mk_cmd(LM_MUL1, a12, b11, '0, '0);
                cmd[3]  = mk_cmd(LM_MUL1, a12, b12, '0, '0);
                o_wmask = 4'b1111;
            end
            FN_ROWMUL: begin
                cmd[0]  = mk_cmd(LM_MUL2, b11, a11, b12, a21);
                cmd[1]  = mk_cmd(LM_MUL2, b11, a12, b12, a22);
                o_wmask = 4'b0011;
            end
            FN_ADD22: begin
                cmd[0]  = mk_cmd(LM_ADD, a11, b11, '0, '0);
                cmd[1]  = mk_cmd(LM_ADD, a12, b12, '0, '0);
                cmd[2]  = mk_cmd(LM_ADD, a21, b21, '0, '0);
                cmd[3]  = mk_cmd(LM_ADD, a22, b22, '0, '0);
                o_wmask = 4'b1111;
            end
            FN_SUB22: begin
                cmd[0]  = mk_cmd(LM_SUB, a11, b11, '0, '0);
                cmd[1]  = mk_cmd(LM_SUB, a12, b12, '0, '0);
                cmd[2]  = mk_cmd(LM_SUB, a21, b21, '0, '0);
                cmd[3]  = mk_cmd(LM_SUB, a22, b22, '0, '0);
                o_wmask = 4'b1111;
            end
            FN_SUB21: begin
                cmd[0]  = mk_cmd(LM_SUB, a11, b11, '0, '0);
                cmd[1]  = mk_cmd(LM_SUB, a12, b12, '0, '0);
                o_wmask = 4'b0011;
            end
            FN_ADD21: begin
                cmd[0]  = mk_cmd(LM_ADD, a11, b11, '0, '0);
                cmd[1]  = mk_cmd(LM_ADD, a12, b12, '0, '0);
                o_wmask = 4'b0011;
            end
            FN_TRANS: begin
                cmd[0]  = mk_cmd(LM_PASS, a11, '0, '0, '0);
                cmd[1]  = mk_cmd(LM_PASS, a21, '0, '0, '0);
                cmd[2]  = mk_cmd(LM_PASS, a12, '0, '0, '0);
                cmd[3]  = mk_cmd(LM_PASS, a22, '0, '0, '0);
                o_wmask = 4'b1111;
            end
            FN_SCALE21: begin
                cmd[0]  = mk_cmd(LM_MUL1, a11, s, '0, '0);
                cmd[1]  = mk_cmd(LM_MUL1, a12, s, '0, '0);
                o_wmask = 4'b0011;
            end
            FN_SCALE22: begin
                cmd[0]  = mk_cmd(LM_MUL1, a11, s, '0, '0);
                cmd[1]  = mk_cmd(LM_MUL1, a12, s, '0, '0);
                cmd[2]  = mk_cmd(LM_MUL1, a21, s, '0, '0);
                cmd[3]  = mk_cmd(LM_MUL1, a22, s, '0, '0);
                o_wmask = 4'b1111;
            end
            default: begin
                o_wmask = '0;   // unused opcodes write nothing
            end
        endcase
    end

    for (genvar g = 0; g < N_ELEM; g++) begin : g_lane
        mat2_lane u_lane (
            .i_cmd (cmd[g]),
            .o_val (o_val[g]),
            .o_sat (lane_sat[g])
        );
    end

    assign o_sat = |(lane_sat & o_wmask);

endmodule

// File: rtl/matrix_2x2_alu.sv
// Top level of the fixed-point 2x2 matrix / 2-element vector ALU.
`timescale 1ns / 1ps

// matrix_2x2_alu: one operation per transaction on Q16.16 operands. A
// transaction is taken at a rising edge with start high and busy low; busy
// is high only while reset is applied, so a new transaction can be issued
// every clock. The operands are registered, the opcode selects one of twelve
// operations, and the four result registers are then updated from them;
// o_done rises with that update and is high for exactly one cycle, with
// res_* and o_saturated valid in that cycle. The receiver cannot stall:
// each o_done pulse must be consumed when it appears. Throughput is one
// transaction per cycle, as the four multiply/add lanes form a single
// combinational pass between the operand and result registers. Result
// elements not written by an operation keep their previous values (they
// stay readable on res_* between pulses); products are floored, results
// saturate to 32 bits and o_saturated reports any clipping of an element
// written by that operation.

module matrix_2x2_alu
    import mat2_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic signed [DATA_WIDTH-1:0] i_a_11,
    input  logic signed [DATA_WIDTH-1:0] i_a_12,
    input  logic signed [DATA_WIDTH-1:0] i_a_21,
    input  logic signed [DATA_WIDTH-1:0] i_a_22,
    input  logic signed [DATA_WIDTH-1:0] i_b_11,
    input  logic signed [DATA_WIDTH-1:0] i_b_12,
    input  logic signed [DATA_WIDTH-1:0] i_b_21,
    input  logic signed [DATA_WIDTH-1:0] i_b_22,
    input  logic signed [DATA_WIDTH-1:0] i_scalar,
    output logic                  o_done,
    output logic signed [DATA_WIDTH-1:0] o_res_11,
    output logic signed [DATA_WIDTH-1:0] o_res_12,
    output logic signed [DATA_WIDTH-1:0] o_res_21,
    output logic signed [DATA_WIDTH-1:0] o_res_22,
    output logic                  o_saturated
);

    // input stage
    logic              r_busy;
    logic              r_in_vld;
    logic [FUNC_W-1:0] r_func;
    t_word             r_a [N_ELEM];
    t_word             r_b [N_ELEM];
    t_word             r_scalar;
    logic              accept;

    // datapath
    t_word             core_val [N_ELEM];
    logic [N_ELEM-1:0] core_wmask;
    logic              core_sat;

    // result stage (the held result elements)
    t_word             r_res [N_ELEM];
    logic              r_sat;
    logic              r_done;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // busy only while reset is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_a[0]   <= i_a_11;
            r_a[1]   <= i_a_12;
            r_a[2]   <= i_a_21;
            r_a[3]   <= i_a_22;
            r_b[0]   <= i_b_11;
            r_b[1]   <= i_b_12;
            r_b[2]   <= i_b_21;
            r_b[3]   <= i_b_22;
            r_scalar <= i_scalar;
        end
    end

    mat2_core u_core (
        .i_func   (r_func),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_scalar (r_scalar),
        .o_val    (core_val),
        .o_wmask  (core_wmask),
        .o_sat    (core_sat)
    );

    // only elements in the write mask are updated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_res[i] <= '0;
            end
            r_sat  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
            if (r_in_vld) begin
                for (int i = 0; i < N_ELEM; i++) begin
                    if (core_wmask[i]) begin
                        r_res[i] <= core_val[i];
                    end
                end
                r_sat <= core_sat;
            end
        end
    end

    assign o_done      = r_done;
    assign o_res_11    = r_res[0];
    assign o_res_12    = r_res[1];
    assign o_res_21    = r_res[2];
    assign o_res_22    = r_res[3];
    assign o_saturated = r_sat;

endmodule

// File: sim/matrix_2x2_alu_tb.sv
// Self-checking testbench for the 2x2 matrix ALU: directed table, then random traffic.
`timescale 1ns / 1ps

// Stimulus comes in two parts, both driven through the start/busy handshake.
// First a short table of directed transactions covers the saturating
// extremes, floor rounding of negative products, the unused opcodes, and
// elements that an operation leaves alone. Then about 2000 random
// transactions follow, and start is dropped at random between most of them.
// A behavioral copy of the four held result elements predicts every result.
// Rows with a result that is obvious by inspection carry a typed-in
// expectation instead. Each o_done pulse is checked field by field against
// the oldest prediction.

module matrix_2x2_alu_tb;
    import mat2_pkg::*;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word Q_ONE    = 32'sh0001_0000;
    localparam t_word LSB_NEG  = 32'shffff_ffff;

    // opcodes above the last defined one write nothing
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 4'd12;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 4'd15;

    localparam int RANDOM_OPS  = 2000;
    localparam int IDLE_PCT    = 38;
    localparam int CALM_FIRST  = 900;   // no idling for this stretch of random ops
    localparam int CALM_LAST   = 1200;
    localparam int DRAIN_WAIT  = 8;     // extra wait after the last result
    localparam int STALL_LIMIT = 1000;  // cycles with no handshake at all

    // One transaction. fixed marks a row whose expected result is typed in.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_word a11, a12, a21, a22;
        t_word b11, b12, b21, b22;
        t_word scl;
        logic  fixed;
        t_word r11, r12, r21, r22;
        logic  sat;
    } t_op_row;

    typedef struct packed {
        t_word r11, r12, r21, r22;
        logic  sat;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] i_func;
    t_word             i_a_11, i_a_12, i_a_21, i_a_22;
    t_word             i_b_11, i_b_12, i_b_21, i_b_22;
    t_word             i_scalar;
    logic              o_done;
    t_word             o_res_11, o_res_12, o_res_21, o_res_22;
    logic              o_saturated;

    // row being driven; the monitor picks up any typed-in expectation from it
    t_op_row           cur_row;

    t_word             held_elems [N_ELEM];   // predicted result registers
    logic              pred_clip;
    t_result           pending_results [$];
    int                mismatch_count;
    int                stall_cycles;
    t_op_row           directed_ops [$];

    matrix_2x2_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_a_11      (i_a_11),
        .i_a_12      (i_a_12),
        .i_a_21      (i_a_21),
        .i_a_22      (i_a_22),
        .i_b_11      (i_b_11),
        .i_b_12      (i_b_12),
        .i_b_21      (i_b_21),
        .i_b_22      (i_b_22),
        .i_scalar    (i_scalar),
        .o_done      (o_done),
        .o_res_11    (o_res_11),
        .o_res_12    (o_res_12),
        .o_res_21    (o_res_21),
        .o_res_22    (o_res_22),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q16.16 product, floored: an arithmetic shift of the exact product.
    function automatic longint qmul(longint x, longint y);
        return (x * y) >>> FRAC_BITS;
    endfunction

    // Write one element with 32-bit saturation.
    function automatic void put_elem(int idx, longint v);
        if (v > longint'(WORD_MAX)) begin
            held_elems[idx] = WORD_MAX;
            pred_clip       = 1'b1;
        end else if (v < longint'(WORD_MIN)) begin
            held_elems[idx] = WORD_MIN;
            pred_clip       = 1'b1;
        end else begin
            held_elems[idx] = v[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic void predict_op(t_op_row r);
        longint a11, a12, a21, a22, b11, b12, b21, b22, s;
        a11 = $signed(r.a11);
        a12 = $signed(r.a12);
        a21 = $signed(r.a21);
        a22 = $signed(r.a22);
        b11 = $signed(r.b11);
        b12 = $signed(r.b12);
        b21 = $signed(r.b21);
        b22 = $signed(r.b22);
        s   = $signed(r.scl);
        pred_clip = 1'b0;
        case (r.func)
            FN_MUL22: begin
                put_elem(0, qmul(a11, b11) + qmul(a12, b21));
                put_elem(1, qmul(a11, b12) + qmul(a12, b22));
                put_elem(2, qmul(a21, b11) + qmul(a22, b21));
                put_elem(3, qmul(a21, b12) + qmul(a22, b22));
            end
            FN_MUL21: begin
                put_elem(0, qmul(a11, b11) + qmul(a12, b12));
                put_elem(1, qmul(a21, b11) + qmul(a22, b12));
            end
            FN_DOT: begin
                put_elem(0, qmul(a11, b11) + qmul(a12, b12));
            end
            FN_OUTER: begin
                put_elem(0, qmul(a11, b11));
                put_elem(1, qmul(a11, b12));
                put_elem(2, qmul(a12, b11));
                put_elem(3, qmul(a12, b12));
            end
            FN_ROWMUL: begin
                put_elem(0, qmul(b11, a11) + qmul(b12, a21));
                put_elem(1, qmul(b11, a12) + qmul(b12, a22));
            end
            FN_ADD22: begin
                put_elem(0, a11 + b11);
                put_elem(1, a12 + b12);
                put_elem(2, a21 + b21);
                put_elem(3, a22 + b22);
            end
            FN_SUB22: begin
                put_elem(0, a11 - b11);
                put_elem(1, a12 - b12);
                put_elem(2, a21 - b21);
                put_elem(3, a22 - b22);
            end
            FN_SUB21: begin
                put_elem(0, a11 - b11);
                put_elem(1, a12 - b12);
            end
            FN_ADD21: begin
                put_elem(0, a11 + b11);
                put_elem(1, a12 + b12);
            end
            FN_TRANS: begin
                put_elem(0, a11);
                put_elem(1, a21);
                put_elem(2, a12);
                put_elem(3, a22);
            end
            FN_SCALE21: begin
                put_elem(0, qmul(a11, s));
                put_elem(1, qmul(a12, s));
            end
            FN_SCALE22: begin
                put_elem(0, qmul(a11, s));
                put_elem(1, qmul(a12, s));
                put_elem(2, qmul(a21, s));
                put_elem(3, qmul(a22, s));
            end
            default: ;  // spare opcodes: registers hold, no clipping
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_op_row mk_row(logic [FUNC_W-1:0] f,
                                       t_word a11, t_word a12, t_word a21, t_word a22,
                                       t_word b11, t_word b12, t_word b21, t_word b22,
                                       t_word scl, logic fixed,
                                       t_word r11, t_word r12, t_word r21, t_word r22,
                                       logic sat);
        t_op_row r;
        r.func  = f;
        r.a11   = a11;
        r.a12   = a12;
        r.a21   = a21;
        r.a22   = a22;
        r.b11   = b11;
        r.b12   = b12;
        r.b21   = b21;
        r.b22   = b22;
        r.scl   = scl;
        r.fixed = fixed;
        r.r11   = r11;
        r.r12   = r12;
        r.r21   = r21;
        r.r22   = r22;
        r.sat   = sat;
        return r;
    endfunction

    // Mix of full-range words, small Q16.16 values near zero, and extremes.
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            8: begin
                case ($urandom_range(0, 3))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    default: return LSB_NEG;
                endcase
            end
            default: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
        endcase
    endfunction

    function automatic t_op_row rand_row();
        logic [FUNC_W-1:0] f;
        if ($urandom_range(0, 99) < 5)
            f = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else
            f = FUNC_W'($urandom_range(FN_MUL22, FN_SCALE22));
        return mk_row(f, rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), 1'b0, '0, '0, '0, '0, 1'b0);
    endfunction

    // Present one transaction from a falling edge and hold it until taken.
    // Idle cycles, if any, come first so start never toggles within a step.
    task automatic issue_op(t_op_row r, bit may_idle);
        if (may_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start    <= 1'b1;
        cur_row  <= r;
        i_func   <= r.func;
        i_a_11   <= r.a11;
        i_a_12   <= r.a12;
        i_a_21   <= r.a21;
        i_a_22   <= r.a22;
        i_b_11   <= r.b11;
        i_b_12   <= r.b12;
        i_b_21   <= r.b21;
        i_b_22   <= r.b22;
        i_scalar <= r.scl;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        @(negedge i_clk);
    endtask

    task automatic flag_mismatch(string what, t_word got, t_word want);
        $display("%0t ns: mismatch on %s: got %08h, expected %08h",
                 $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted transaction, check each o_done.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (start && !busy) begin
            predict_op(cur_row);
            if (cur_row.fixed)
                want = '{cur_row.r11, cur_row.r12, cur_row.r21, cur_row.r22, cur_row.sat};
            else
                want = '{held_elems[0], held_elems[1], held_elems[2], held_elems[3],
                         pred_clip};
            pending_results.push_back(want);
        end
        if (o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: o_done with no transaction outstanding", $realtime);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res_11 !== want.r11)
                    flag_mismatch("res_11", o_res_11, want.r11);
                if (o_res_12 !== want.r12)
                    flag_mismatch("res_12", o_res_12, want.r12);
                if (o_res_21 !== want.r21)
                    flag_mismatch("res_21", o_res_21, want.r21);
                if (o_res_22 !== want.r22)
                    flag_mismatch("res_22", o_res_22, want.r22);
                if (o_saturated !== want.sat)
                    flag_mismatch("saturated", t_word'(o_saturated), t_word'(want.sat));
            end
        end
        if ((start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: a hung handshake ends the run.
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        cur_row        = '0;
        i_func         = '0;
        i_a_11         = '0;
        i_a_12         = '0;
        i_a_21         = '0;
        i_a_22         = '0;
        i_b_11         = '0;
        i_b_12         = '0;
        i_b_21         = '0;
        i_b_22         = '0;
        i_scalar       = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        for (int k = 0; k < N_ELEM; k++)
            held_elems[k] = '0;

        // Directed table. Typed-in rows form a chain: each relies on the
        // elements left behind by the row before it.
        // spare opcode right after reset: everything still zero
        directed_ops.push_back(mk_row(FUNC_SPARE_LO, 32'h1234_5678, WORD_MAX, WORD_MIN, Q_ONE,
            LSB_NEG, Q_ONE, WORD_MAX, WORD_MIN, WORD_MAX,
            1'b1, '0, '0, '0, '0, 1'b0));
        // transpose passes the extremes through untouched
        directed_ops.push_back(mk_row(FN_TRANS, WORD_MAX, WORD_MIN, 32'sh1, LSB_NEG,
            '0, '0, '0, '0, '0,
            1'b1, WORD_MAX, 32'sh1, WORD_MIN, LSB_NEG, 1'b0));
        // positive overflow on every element
        directed_ops.push_back(mk_row(FN_ADD22, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
            WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0,
            1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
        // negative overflow on every element
        directed_ops.push_back(mk_row(FN_SUB22, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
            WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0,
            1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1));
        // vector add clips its two elements, row 2 holds
        directed_ops.push_back(mk_row(FN_ADD21, WORD_MAX, WORD_MAX, '0, '0,
            32'sh1, 32'sh1, '0, '0, '0,
            1'b1, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b1));
        directed_ops.push_back(mk_row(FN_SUB21, WORD_MIN, WORD_MIN, '0, '0,
            32'sh1, 32'sh1, '0, '0, '0,
            1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1));
        // spare opcode holds everything and clears the flag
        directed_ops.push_back(mk_row(FUNC_SPARE_HI, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
            WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
            1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0));
        // most negative squared, summed: far above the positive limit
        directed_ops.push_back(mk_row(FN_MUL22, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
            WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0,
            1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
        directed_ops.push_back(mk_row(FN_SCALE22, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
            '0, '0, '0, '0, WORD_MAX,
            1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1));
        directed_ops.push_back(mk_row(FN_SCALE22, '0, '0, '0, '0,
            '0, '0, '0, '0, WORD_MAX,
            1'b1, '0, '0, '0, '0, 1'b0));
        // floor rounding: -1 LSB times 1 LSB stays -1 LSB, +1 LSB drops to 0
        directed_ops.push_back(mk_row(FN_SCALE21, LSB_NEG, 32'sh1, '0, '0,
            '0, '0, '0, '0, 32'sh1,
            1'b1, LSB_NEG, '0, '0, '0, 1'b0));
        // dot product writes only the first element
        directed_ops.push_back(mk_row(FN_DOT, WORD_MAX, WORD_MAX, '0, '0,
            WORD_MAX, WORD_MAX, '0, '0, '0,
            1'b1, WORD_MAX, '0, '0, '0, 1'b1));
        // ordinary values, predicted
        directed_ops.push_back(mk_row(FN_MUL22, Q_ONE, '0, '0, Q_ONE,
            32'sh0002_8000, -32'sh0001_4000, 32'sh0000_0003, LSB_NEG, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_MUL22, 32'sh0003_0000, -32'sh0000_8001,
            32'sh7000_0000, 32'sh7000_0000, 32'sh0001_8000, 32'sh0000_0007,
            32'sh0002_0000, -32'sh0002_0000, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_MUL21, -32'sh0001_8000, 32'sh0000_4000,
            32'sh0010_0000, LSB_NEG, 32'sh0000_0005, -32'sh0003_0000, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_DOT, -32'sh0000_0003, 32'sh0000_0007, '0, '0,
            32'sh0000_0005, -32'sh0000_0002, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_OUTER, LSB_NEG, -32'sh0002_0001, '0, '0,
            32'sh0000_0001, 32'sh0003_0000, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_ROWMUL, 32'sh0001_0000, 32'sh0002_0000,
            -32'sh0003_0000, 32'sh0000_8000, -32'sh0000_4000, 32'sh0001_1111, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_ADD22, 32'sh4000_0000, -32'sh4000_0000,
            32'sh0000_1234, WORD_MIN, 32'sh3fff_ffff, -32'sh4000_0000,
            -32'sh0000_1234, 32'sh0000_0001, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_SUB22, WORD_MIN, WORD_MAX, '0, 32'sh1,
            LSB_NEG, WORD_MIN, WORD_MIN, WORD_MAX, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_SCALE21, -32'sh0001_8000, 32'sh0123_4567, '0, '0,
            '0, '0, '0, '0, -32'sh0000_8001,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_ADD21, -32'sh0000_0001, 32'sh3fff_0000, '0, '0,
            32'sh0000_0001, 32'sh0000_ffff, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));
        directed_ops.push_back(mk_row(FN_TRANS, 32'sh1111_1111, 32'sh2222_2222,
            32'sh3333_3333, 32'sh4444_4444, '0, '0, '0, '0, '0,
            1'b0, '0, '0, '0, '0, 1'b0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_ops[k])
            issue_op(directed_ops[k], 1'b1);

        for (int k = 0; k < RANDOM_OPS; k++)
            issue_op(rand_row(), !(k >= CALM_FIRST && k < CALM_LAST));
        start <= 1'b0;

        // drain: every prediction must be met, then allow a few more cycles
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/mat2_pkg.sv
rtl/mat2_lane.sv
rtl/mat2_core.sv
rtl/matrix_2x2_alu.sv
sim/matrix_2x2_alu_tb.sv
